// File: hdl/weighted_round_robin_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted round robin scheduler
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define WRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared types and constants of the weighted round robin scheduler.
// ----------------------------------------------------------------------------
package wrr_pkg;

    localparam int WRR_NUM_QUEUES = 4;
    localparam int WRR_WEIGHT_W   = 8;
    localparam int WRR_CW_W       = 9;
    localparam int WRR_CFG_REGS   = 4;
    localparam int WRR_CFG_IDX_W  = 8;
    localparam int WRR_TDATA_W    = 8;

    typedef struct packed {
        logic [WRR_WEIGHT_W-1:0] gcd;
        logic [WRR_WEIGHT_W-1:0] max;
    } t_wrr_params;

    typedef enum logic [1:0] {
        GCD_IDLE,
        GCD_LOAD,
        GCD_EUCLID
    } t_wrr_gcd_state;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } t_wrr_scan_state;

endpackage

// File: hdl/wrr_gcd.sv
// ----------------------------------------------------------------------------
// wrr_gcd
// Derives gcd (subtractive Euclid) and maximum of all weights, one queue at
// a time, through a single shared comparator and subtractor.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_scheduler_unit_macros.svh"

module wrr_gcd #(
    parameter int NUM_QUEUES = wrr_pkg::WRR_NUM_QUEUES,
    localparam int PW = $clog2(NUM_QUEUES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic [PW-1:0]                       o_rd_idx,
    input  logic [wrr_pkg::WRR_WEIGHT_W-1:0]    i_rd_data,
    output logic                                o_busy,
    output wrr_pkg::t_wrr_params                o_params
);
    import wrr_pkg::*;

    localparam logic [PW-1:0] LAST = PW'(NUM_QUEUES - 1);

    t_wrr_gcd_state          r_state, n_state;
    logic [PW-1:0]           r_idx, n_idx;
    logic [WRR_WEIGHT_W-1:0] r_a, n_a;
    logic [WRR_WEIGHT_W-1:0] r_b, n_b;
    logic [WRR_WEIGHT_W-1:0] r_max_acc, n_max_acc;
    logic [WRR_WEIGHT_W-1:0] r_gcd, n_gcd;
    logic [WRR_WEIGHT_W-1:0] r_max, n_max;
    logic [WRR_WEIGHT_W-1:0] cmp_x, cmp_y, diff;
    logic                    cmp_lt;

    always_comb begin
        if (r_state == GCD_LOAD) begin
            cmp_x = r_max_acc;
            cmp_y = i_rd_data;
        end else begin
            cmp_x = r_a;
            cmp_y = r_b;
        end
        cmp_lt = cmp_x < cmp_y;
        diff   = cmp_x - cmp_y;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            GCD_IDLE:   if (i_start) n_state = GCD_LOAD;
            GCD_LOAD:   n_state = GCD_EUCLID;
            GCD_EUCLID: begin
                if (r_b == '0) begin
                    n_state = (r_idx == LAST) ? GCD_IDLE : GCD_LOAD;
                end
            end
            default:    n_state = GCD_IDLE;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_a       = r_a;
        n_b       = r_b;
        n_max_acc = r_max_acc;
        n_gcd     = r_gcd;
        n_max     = r_max;
        unique case (r_state)
            GCD_IDLE: begin
                if (i_start) begin
                    n_idx     = '0;
                    n_a       = '0;
                    n_max_acc = '0;
                end
            end
            GCD_LOAD: begin
                n_b = i_rd_data;
                if (cmp_lt) n_max_acc = i_rd_data;
            end
            GCD_EUCLID: begin
                if (r_b == '0) begin
                    if (r_idx == LAST) begin
                        n_gcd = r_a;
                        n_max = r_max_acc;
                    end else begin
                        n_idx = PW'(r_idx + 1'b1);
                    end
                end else if (cmp_lt) begin
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    n_a = diff;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GCD_IDLE;
            r_gcd   <= WRR_WEIGHT_W'(1);
            r_max   <= WRR_WEIGHT_W'(1);
        end else begin
            r_state <= n_state;
            r_gcd   <= n_gcd;
            r_max   <= n_max;
        end
        r_idx     <= n_idx;
        r_a       <= n_a;
        r_b       <= n_b;
        r_max_acc <= n_max_acc;
    end

    assign o_rd_idx     = r_idx;
    assign o_busy       = (r_state != GCD_IDLE);
    assign o_params.gcd = r_gcd;
    assign o_params.max = r_max;

    `WRR_ASSERT_NOW(a_gcd_zero_iff_max_zero, 1'b1, ((r_gcd == '0) == (r_max == '0)), "gcd/max zero mismatch")
    `WRR_ASSERT_NEXT(a_start_goes_busy, (r_state == GCD_IDLE) && i_start, r_state == GCD_LOAD, "derive did not start")
    `WRR_ASSERT_NOW(a_max_bounds_gcd, (r_state == GCD_IDLE) && (r_gcd != '0), r_gcd <= r_max, "gcd above max")

endmodule

// File: hdl/wrr_scan.sv
// ----------------------------------------------------------------------------
// wrr_scan
// Queue pointer walk: one queue per cycle; at each wrap the current weight
// drops by the gcd or reloads max; stops at the first qualifying queue.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_scheduler_unit_macros.svh"

module wrr_scan #(
    parameter int NUM_QUEUES = wrr_pkg::WRR_NUM_QUEUES,
    localparam int PW = $clog2(NUM_QUEUES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  wrr_pkg::t_wrr_params                i_params,
    output logic [PW-1:0]                       o_rd_idx,
    input  logic [wrr_pkg::WRR_WEIGHT_W-1:0]    i_rd_data,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [PW-1:0]                       o_queue
);
    import wrr_pkg::*;

    localparam logic [PW-1:0] LAST = PW'(NUM_QUEUES - 1);

    t_wrr_scan_state     r_state, n_state;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [WRR_CW_W-1:0] r_cw, n_cw;
    logic [PW-1:0]       step_ptr;
    logic [WRR_CW_W-1:0] step_cw;
    logic [WRR_CW_W-1:0] gcd_ext;
    logic                wrap, hit;

    always_comb begin
        gcd_ext  = WRR_CW_W'(i_params.gcd);
        wrap     = (r_ptr == LAST);
        step_ptr = wrap ? '0 : PW'(r_ptr + 1'b1);
        if (!wrap) begin
            step_cw = r_cw;
        end else if (r_cw <= gcd_ext) begin
            step_cw = WRR_CW_W'(i_params.max);
        end else begin
            step_cw = r_cw - gcd_ext;
        end
        hit = WRR_CW_W'(i_rd_data) >= step_cw;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SCAN_IDLE: if (i_start) n_state = SCAN_RUN;
            SCAN_RUN:  if (hit) n_state = SCAN_IDLE;
            default:   n_state = SCAN_IDLE;
        endcase
    end

    always_comb begin
        n_ptr  = r_ptr;
        n_cw   = r_cw;
        o_done = 1'b0;
        unique case (r_state)
            SCAN_IDLE: ;
            SCAN_RUN: begin
                n_ptr  = step_ptr;
                n_cw   = step_cw;
                o_done = hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_IDLE;
            r_ptr   <= LAST;
            r_cw    <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cw    <= n_cw;
        end
    end

    assign o_rd_idx = step_ptr;
    assign o_queue  = step_ptr;
    assign o_busy   = (r_state == SCAN_RUN);

    `WRR_ASSERT_NOW(a_scan_needs_weight, r_state == SCAN_RUN, i_params.max != '0, "scan with zero weights")
    `WRR_ASSERT_NOW(a_cw_in_range, 1'b1, r_cw[WRR_CW_W-1] == 1'b0, "current weight overflow")
    `WRR_ASSERT_NEXT(a_cw_nonzero_after_done, o_done, r_cw != '0, "granted at zero weight")

endmodule

// File: hdl/weighted_round_robin_scheduler_unit.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler_unit
// Interleaved weighted round robin grant over NUM_QUEUES queues.
// ----------------------------------------------------------------------------
// A word with tdata bit 0 set asks for a grant; one result word follows the
// cycle after the scan finds a queue. The scan visits one queue per cycle,
// so in steady state a grant visits at most NUM_QUEUES queues, and more (up
// to one round per gcd step) right after a weight change left the current
// weight high. A word with bit 0 clear is taken without a scan and gives no
// result; all weights zero gives one result with grant_valid low at once.
// Every weight write starts a gcd/max pass that walks the queues through
// one shared compare/subtract: a load step per queue followed by its Euclid
// steps; requests and writes wait, and a pending write holds off requests.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_scheduler_unit_macros.svh"

module weighted_round_robin_scheduler_unit #(
    parameter int NUM_QUEUES = wrr_pkg::WRR_NUM_QUEUES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [wrr_pkg::WRR_TDATA_W-1:0]      i_s_tdata,   // [0] grant_request
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [wrr_pkg::WRR_TDATA_W-1:0]      o_m_tdata,   // [1:0] granted_queue, [2] grant_valid
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wrr_pkg::WRR_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wrr_pkg::WRR_WEIGHT_W-1:0]     i_cfg_data
);
    import wrr_pkg::*;

    localparam int PW = $clog2(NUM_QUEUES);

    logic [WRR_WEIGHT_W-1:0] r_weight [NUM_QUEUES];
    logic                    r_out_valid;
    logic [1:0]              r_out_queue;
    logic                    r_out_gv;

    t_wrr_params             params;
    logic                    gcd_busy, scan_busy, scan_done;
    logic [PW-1:0]           gcd_idx, scan_idx, scan_queue, rd_idx;
    logic [WRR_WEIGHT_W-1:0] rd_data;
    logic [PW+1:0]           queue_ext;
    logic                    s_fire, cfg_fire, cfg_hit, request, weights_live, scan_start;

    assign o_cfg_ready  = !gcd_busy && !scan_busy;
    assign o_s_tready   = !gcd_busy && !scan_busy && !i_cfg_valid
                       && (!r_out_valid || i_m_tready);
    assign s_fire       = i_s_tvalid && o_s_tready;
    assign cfg_fire     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit      = (i_cfg_index < WRR_CFG_IDX_W'(WRR_CFG_REGS))
                       && (i_cfg_index < WRR_CFG_IDX_W'(NUM_QUEUES));
    assign request      = i_s_tdata[0];
    assign weights_live = (params.max != '0) && (params.gcd != '0);
    assign scan_start   = s_fire && request && weights_live;
    assign rd_idx       = gcd_busy ? gcd_idx : scan_idx;
    assign rd_data      = r_weight[rd_idx];
    assign queue_ext    = {2'b00, scan_queue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_weight[i] <= WRR_WEIGHT_W'(1);
            end
        end else if (cfg_fire && cfg_hit) begin
            r_weight[i_cfg_index[PW-1:0]] <= i_cfg_data;
        end
    end

    wrr_gcd #(.NUM_QUEUES(NUM_QUEUES)) u_gcd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_fire),
        .o_rd_idx  (gcd_idx),
        .i_rd_data (rd_data),
        .o_busy    (gcd_busy),
        .o_params  (params)
    );

    wrr_scan #(.NUM_QUEUES(NUM_QUEUES)) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_params  (params),
        .o_rd_idx  (scan_idx),
        .i_rd_data (rd_data),
        .o_busy    (scan_busy),
        .o_done    (scan_done),
        .o_queue   (scan_queue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_done) begin
            r_out_valid <= 1'b1;
            r_out_queue <= queue_ext[1:0];
            r_out_gv    <= 1'b1;
        end else if (s_fire && request && !weights_live) begin
            r_out_valid <= 1'b1;
            r_out_queue <= 2'b00;
            r_out_gv    <= 1'b0;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(WRR_TDATA_W - 3)'(0), r_out_gv, r_out_queue};

    `WRR_ASSERT_NOW(a_no_accept_in_derive, gcd_busy, !o_s_tready && !o_cfg_ready, "accept while deriving")
    `WRR_ASSERT_NOW(a_one_in_flight, scan_busy, !r_out_valid, "scan while result pending")
    `WRR_ASSERT_NEXT(a_done_loads_result, scan_done, r_out_valid && r_out_gv, "grant lost")

endmodule

// File: tb/tb_weighted_round_robin_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_round_robin_scheduler_unit
// Self-checking bench for the weighted round robin scheduler.
// ----------------------------------------------------------------------------
// A directed table (reset weights, a single heavy queue, all weights zero,
// ignored register indexes, a weight drop below the current weight) is
// followed by random phases. Each phase first waits until the block is idle,
// rewrites the weights and then sends request words in bursts. A local
// predictor tracks weights, gcd, maximum, pointer and current weight, and
// every result word is checked against the oldest pending grant. The result
// side stalls on changing patterns, and twice it holds off for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_weighted_round_robin_scheduler_unit;
    import wrr_pkg::*;

    localparam int         HALF_PERIOD     = 2;
    localparam int         RESET_CYCLES    = 12;
    localparam int         REQUEST_TARGET  = 750;
    localparam int         IDLE_PAUSE      = 16;
    localparam int         TAIL_CYCLES     = 64;
    localparam int         PRESSURE_CYCLES = 400;
    localparam int         WATCHDOG_LIMIT  = 8000;
    localparam int         REPORT_LIMIT    = 10;

    localparam logic [7:0] REG_WEIGHT_0    = 8'd0;
    localparam logic [7:0] REG_WEIGHT_1    = 8'd1;
    localparam logic [7:0] REG_WEIGHT_2    = 8'd2;
    localparam logic [7:0] REG_WEIGHT_3    = 8'd3;
    localparam logic [7:0] REG_PAST_LAST   = 8'(WRR_CFG_REGS);
    localparam logic [7:0] REG_TOP_INDEX   = 8'hFF;

    typedef struct packed {
        logic       valid;
        logic [1:0] queue;
    } t_grant;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       req;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic       typed;
        logic [1:0] tq;
        logic       tv;
    } t_stim_row;

    localparam int N_DIRECTED = 40;

    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b1},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd1, 1'b1},
        '{ROW_REQ, 1'b0, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd2, 1'b1},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd3, 1'b1},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b1},
        '{ROW_CFG, 1'b0, REG_WEIGHT_1, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_2, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_3, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_0, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b1},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b1},
        '{ROW_CFG, 1'b0, REG_WEIGHT_0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_PAST_LAST, 8'h55, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_TOP_INDEX, 8'hAA, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b1, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_0, 8'd200, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_1, 8'd200, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_2, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_3, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_0, 8'd3, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_1, 8'd6, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_2, 8'd9, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_3, 8'd3, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_0, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_1, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_2, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_CFG, 1'b0, REG_WEIGHT_3, 8'd255, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b1, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0},
        '{ROW_REQ, 1'b0, 8'd0, 8'd0, 1'b0, 2'd0, 1'b0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [WRR_TDATA_W-1:0]     i_s_tdata;    // [0] grant_request
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [WRR_TDATA_W-1:0]     o_m_tdata;    // [1:0] granted_queue, [2] grant_valid
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [WRR_CFG_IDX_W-1:0]   i_cfg_index;
    logic [WRR_WEIGHT_W-1:0]    i_cfg_data;

    // row tag travelling with the request word
    logic                       typed_row;
    logic [1:0]                 typed_queue;
    logic                       typed_valid;

    logic [WRR_WEIGHT_W-1:0]    weight_q [WRR_NUM_QUEUES];
    logic [1:0]                 scan_ptr;
    int                         level;
    logic [WRR_WEIGHT_W-1:0]    step_gcd;
    logic [WRR_WEIGHT_W-1:0]    top_weight;

    t_grant                     grants_due [$];
    t_grant                     want_g;
    t_grant                     got_g;
    t_grant                     pick_g;
    int                         mismatches;
    int                         idle_run;
    int                         burst_left;
    bit                         pressure_req;

    weighted_round_robin_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic void refresh_weights();
        int unsigned g;
        int unsigned m;
        int unsigned a;
        int unsigned b;
        int unsigned r;
        g = 0;
        m = 0;
        for (int i = 0; i < WRR_NUM_QUEUES; i++) begin
            a = g;
            b = weight_q[i];
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            g = a;
            if (weight_q[i] > m) begin
                m = weight_q[i];
            end
        end
        step_gcd   = g[7:0];
        top_weight = m[7:0];
    endfunction

    function automatic void apply_weight_write(logic [7:0] idx, logic [7:0] val);
        if (idx < WRR_CFG_REGS && idx < WRR_NUM_QUEUES) begin
            weight_q[idx] = val;
            refresh_weights();
        end
    endfunction

    function automatic t_grant next_grant();
        t_grant      g;
        int unsigned p;
        int          lvl;
        g.queue = 2'd0;
        g.valid = 1'b0;
        if (top_weight == 0 || step_gcd == 0) begin
            return g;
        end
        p   = scan_ptr;
        lvl = level;
        for (int n = 0; n < 600 * WRR_NUM_QUEUES; n++) begin
            p = (p + 1) % WRR_NUM_QUEUES;
            if (p == 0) begin
                lvl = lvl - int'(step_gcd);
                if (lvl <= 0) begin
                    lvl = int'(top_weight);
                end
            end
            if (int'(weight_q[p]) >= lvl) begin
                break;
            end
        end
        scan_ptr = p[1:0];
        level    = lvl;
        g.queue  = p[1:0];
        g.valid  = 1'b1;
        return g;
    endfunction

    function automatic logic [7:0] pick_weight(int unsigned f);
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(1, 4));
            3, 4: return 8'(f * $urandom_range(0, 255 / f));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // predictor and checker, all on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_weight_write(i_cfg_index, i_cfg_data);
            end
            if (i_s_tvalid && o_s_tready && i_s_tdata[0]) begin
                pick_g = next_grant();
                if (typed_row) begin
                    pick_g.queue = typed_queue;
                    pick_g.valid = typed_valid;
                end
                grants_due.push_back(pick_g);
            end
            if (o_m_tvalid && i_m_tready) begin
                got_g = o_m_tdata[2:0];
                if (grants_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected word: queue %0d valid %0b",
                                 $realtime, got_g.queue, got_g.valid);
                    end
                end else begin
                    want_g = grants_due.pop_front();
                    if (got_g.queue !== want_g.queue || got_g.valid !== want_g.valid) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: expected queue %0d valid %0b, got queue %0d valid %0b",
                                     $realtime, want_g.queue, want_g.valid,
                                     got_g.queue, got_g.valid);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: stall patterns plus long hold-offs on request
    initial begin : rx_side
        int mode;
        int seg;
        int hold;
        int tick;
        i_m_tready = 1'b0;
        hold = 0;
        tick = 0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 150);
            repeat (seg) begin
                @(negedge i_clk);
                tick++;
                if (pressure_req && hold == 0) begin
                    hold = PRESSURE_CYCLES;
                    pressure_req = 1'b0;
                end
                if (hold > 0) begin
                    hold--;
                    i_m_tready <= 1'b0;
                end else begin
                    case (mode)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        2: i_m_tready <= ($urandom_range(0, 3) == 0);
                        default: i_m_tready <= ((tick % 7) < 4);
                    endcase
                end
            end
        end
    end

    // offer one word, in bursts separated by random gaps
    task automatic send_word(logic req, logic typed, logic [1:0] tq, logic tv);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= {{(WRR_TDATA_W-1){1'b0}}, req};
        typed_row   <= typed;
        typed_queue <= tq;
        typed_valid <= tv;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic write_weight_reg(logic [7:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // stop offering, wait for every pending grant, then let the block settle
    task automatic drain_grants();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (grants_due.size() != 0) @(negedge i_clk);
        repeat (IDLE_PAUSE) @(negedge i_clk);
    endtask

    initial begin : stim_side
        int          requests;
        int          phase;
        int          n;
        int unsigned f;
        logic        last_req;
        logic        req;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        typed_row    = 1'b0;
        typed_queue  = 2'd0;
        typed_valid  = 1'b0;
        mismatches   = 0;
        idle_run     = 0;
        burst_left   = 0;
        pressure_req = 1'b0;
        for (int i = 0; i < WRR_NUM_QUEUES; i++) begin
            weight_q[i] = 8'd1;
        end
        scan_ptr = 2'(WRR_NUM_QUEUES - 1);
        level    = 0;
        refresh_weights();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        last_req = 1'b0;
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (last_req) begin
                    drain_grants();
                end
                write_weight_reg(directed_rows[r].addr, directed_rows[r].wdata);
                last_req = 1'b0;
            end else begin
                if (!last_req) begin
                    i_cfg_valid <= 1'b0;
                end
                send_word(directed_rows[r].req, directed_rows[r].typed,
                          directed_rows[r].tq, directed_rows[r].tv);
                last_req = 1'b1;
            end
        end

        requests = 0;
        phase    = 0;
        while (requests < REQUEST_TARGET) begin
            drain_grants();
            f = $urandom_range(1, 40);
            for (int r = 0; r < WRR_CFG_REGS; r++) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_weight_reg(8'(r), pick_weight(f));
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                write_weight_reg(8'($urandom_range(WRR_CFG_REGS, 255)),
                                 8'($urandom_range(0, 255)));
            end
            i_cfg_valid <= 1'b0;
            if (phase == 1 || phase == 5) begin
                pressure_req = 1'b1;
            end
            n = $urandom_range(40, 110);
            repeat (n) begin
                req = ($urandom_range(0, 7) != 0);
                send_word(req, 1'b0, 2'd0, 1'b0);
                requests++;
            end
            phase++;
        end

        drain_grants();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
